// ===== hdl/cps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types, constants and helpers for the cookie pair splitter.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int KEY_CAPACITY   = 256;
    localparam int VALUE_CAPACITY = 4096;

    localparam int KEY_W = $clog2(KEY_CAPACITY);
    localparam int VAL_W = $clog2(VALUE_CAPACITY);

    // Longest key and value that still fit (one slot kept for the end mark)
    localparam logic [KEY_W-1:0] KEY_LEN_MAX = KEY_W'(KEY_CAPACITY - 1);
    localparam logic [VAL_W-1:0] VAL_LEN_MAX = VAL_W'(VALUE_CAPACITY - 1);

    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_TAB    = 8'h09;

    typedef enum logic [1:0] {
        PHASE_NAME  = 2'd0,
        PHASE_VALUE = 2'd1,
        PHASE_SEMI  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_DROP  = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2
    } role_t;

    typedef struct packed {
        phase_t            phase;
        logic [KEY_W-1:0]  key_len;
        logic [VAL_W-1:0]  val_len;
        logic              err;
    } parse_state_t;

    typedef struct packed {
        logic [7:0] byte_val;
        role_t      role;
        logic       commit;
        logic       err;
        logic       done;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:   PHASE_NAME,
        key_len: '0,
        val_len: '0,
        err:     1'b0
    };

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_CR, CHAR_LF, CHAR_TAB};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/cookie_pair_splitter_top.sv =====
// Results are registered: a result appears in the cycle after its byte transfer.
// Throughput: one byte per cycle; the single result register drains while
//   the next byte is taken, so in_stall follows out_stall only when full.
// Reset: rst_n clears parser state to the name phase with zero counts and
//   no error, and empties the result register. No clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// cookie_pair_splitter_top
// Tags Cookie header bytes as key, value or dropped and marks pair ends.
// ----------------------------------------------------------------------------
module cookie_pair_splitter_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       byte_in,
    input  wire logic             final_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            byte_out,
    output logic [1:0]            byte_role,
    output logic                  pair_commit,
    output logic                  overflow_error,
    output logic                  string_done
);
    import cps_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      step_res;
    result_t      res_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_xfer;

    cps_parser_core u_core (
        .state      (state_reg),
        .byte_in    (byte_in),
        .final_byte (final_byte),
        .state_next (state_next),
        .result     (step_res)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                state_reg <= state_next;
            end
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_out       = res_reg.byte_val;
    assign byte_role      = res_reg.role;
    assign pair_commit    = res_reg.commit;
    assign overflow_error = res_reg.err;
    assign string_done    = res_reg.done;

`ifndef SYNTHESIS
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && final_byte |=> state_reg == STATE_RESET)
        else $error("parser state not cleared after final byte");

    a_err_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.err |-> res_reg.role == ROLE_DROP)
        else $error("byte tagged while overflow flagged");

    a_no_commit_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.commit |-> !res_reg.err)
        else $error("pair committed during overflow");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && state_reg.err && !final_byte |=> state_reg.err)
        else $error("overflow flag dropped before end of string");
`endif

endmodule
`default_nettype wire

// ===== hdl/cps_parser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cps_parser_core
// One-byte step of the cookie parser: next state and tagged result.
// ----------------------------------------------------------------------------
module cps_parser_core (
    input  cps_pkg::parse_state_t state,
    input  logic [7:0]            byte_in,
    input  logic                  final_byte,
    output cps_pkg::parse_state_t state_next,
    output cps_pkg::result_t      result
);
    import cps_pkg::*;

    parse_state_t upd;
    role_t        role;
    logic         commit;

    always_comb
    begin
        upd    = state;
        role   = ROLE_DROP;
        commit = 1'b0;
        if (!state.err)
        begin
            case (state.phase)
                PHASE_VALUE:
                begin
                    if (byte_in == CHAR_SEMI)
                    begin
                        upd.phase = PHASE_SEMI;
                    end
                    else if (state.val_len >= VAL_LEN_MAX)
                    begin
                        upd.err = 1'b1;
                    end
                    else
                    begin
                        upd.val_len = state.val_len + VAL_W'(1);
                        role        = ROLE_VALUE;
                    end
                end
                PHASE_SEMI:
                begin
                    // first non-blank byte closes the pending pair and opens a key
                    if (!is_blank(byte_in))
                    begin
                        commit      = 1'b1;
                        upd.key_len = KEY_W'(1);
                        upd.val_len = '0;
                        upd.phase   = PHASE_NAME;
                        role        = ROLE_KEY;
                    end
                end
                default:
                begin
                    if (byte_in == CHAR_EQUALS)
                    begin
                        upd.phase = PHASE_VALUE;
                    end
                    else if (state.key_len >= KEY_LEN_MAX)
                    begin
                        upd.err = 1'b1;
                    end
                    else
                    begin
                        upd.key_len = state.key_len + KEY_W'(1);
                        role        = ROLE_KEY;
                    end
                end
            endcase
        end

        if (final_byte && !upd.err && (upd.key_len != '0) && (upd.val_len != '0))
        begin
            commit = 1'b1;
        end
    end

    always_comb
    begin
        result.byte_val = byte_in;
        result.role     = role;
        result.commit   = commit;
        result.err      = upd.err;
        result.done     = final_byte;
        // start the next string from a clean state
        state_next      = final_byte ? STATE_RESET : upd;
    end

endmodule
`default_nettype wire
